### sv/complex_polar_split_join_assert.svh
// Assertion macros for the complex polar split/join RTL.
`ifndef COMPLEX_POLAR_SPLIT_JOIN_ASSERT_SVH
`define COMPLEX_POLAR_SPLIT_JOIN_ASSERT_SVH
`ifndef SYNTHESIS
`define CPSJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsj assertion failed");
`define CPSJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsj assertion failed");
`else
`define CPSJ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPSJ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/cpsj_pkg.sv
// Shared types and constants of the complex polar split/join block.
`default_nettype none
package cpsj_pkg;
    localparam int unsigned RootBits = 16;
    localparam int unsigned QuotBits = 15;

    typedef enum logic {
        MODE_SPLIT = 1'b0,
        MODE_JOIN  = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [15:0]        ure;
        logic [15:0]        uim;
        logic [15:0]        jre;
        logic [15:0]        jim;
        logic [31:0]        pre;
        logic [31:0]        pim;
        logic [31:0]        sq;
        logic [15:0]        root;
        logic [15:0]        mag;
        logic [31:0]        nre;
        logic [31:0]        nim;
        logic [14:0]        qre;
        logic [14:0]        qim;
        logic               ovre;
        logic               ovim;
    } t_stage;

    localparam logic signed [15:0] SatPos = 16'sh7FFF;
    localparam logic signed [15:0] SatNeg = 16'sh8000;
endpackage
`default_nettype wire

### sv/cpsj_if.sv
// Valid/ready channel interfaces for samples, results and the mode register.
`default_nettype none
interface cpsj_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] in_re;
    logic signed [15:0] in_im;
    logic [15:0]        in_mag;
    modport source (output valid, in_re, in_im, in_mag, input ready);
    modport sink (input valid, in_re, in_im, in_mag, output ready);
endinterface

interface cpsj_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic [15:0]        out_mag;
    modport source (output valid, out_re, out_im, out_mag, input ready);
    modport sink (input valid, out_re, out_im, out_mag, output ready);
endinterface

interface cpsj_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

### sv/cpsj_front.sv
// Front stages: squares and join-mode products, then the sum and rounded join result.
`default_nettype none
module cpsj_front
    import cpsj_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_vld,
    input  wire t_stage i_data,
    output logic        o_vld,
    output t_stage      o_data
);
    logic   r_va, r_vb;
    t_stage r_a, r_b;
    t_stage n_a, n_b;

    function automatic logic [15:0] join_sat(input logic neg, input logic [31:0] p);
        logic [31:0] q;
        logic [15:0] res;
        q = (p + 32'd16384) >> 15;
        if (neg) begin
            res = (q >= 32'd32768) ? SatNeg : 16'(-q);
        end else begin
            res = (q >= 32'd32767) ? SatPos : q[15:0];
        end
        return res;
    endfunction

    always_comb begin
        n_a     = i_data;
        n_a.ure = i_data.re[15] ? 16'(-i_data.re) : i_data.re;
        n_a.uim = i_data.im[15] ? 16'(-i_data.im) : i_data.im;
        n_a.nre = 32'(n_a.ure) * 32'(n_a.ure);
        n_a.nim = 32'(n_a.uim) * 32'(n_a.uim);
        n_a.pre = 32'(n_a.ure) * 32'(i_data.mag);
        n_a.pim = 32'(n_a.uim) * 32'(i_data.mag);
    end

    always_comb begin
        n_b     = r_a;
        n_b.sq  = r_a.nre + r_a.nim;
        n_b.jre = join_sat(r_a.re[15], r_a.pre);
        n_b.jim = join_sat(r_a.im[15], r_a.pim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_vld  = r_vb;
    assign o_data = r_b;
endmodule
`default_nettype wire

### sv/cpsj_sqrt.sv
// Pipelined square root, one root bit per stage, followed by a rounding stage.
`default_nettype none
module cpsj_sqrt
    import cpsj_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_vld,
    input  wire t_stage i_data,
    output logic        o_vld,
    output t_stage      o_data
);
    logic   r_v [0:RootBits];
    t_stage r_d [0:RootBits];

    for (genvar g = 0; g < RootBits; g++) begin : g_step
        localparam int unsigned K = RootBits - 1 - g;
        t_stage      src, n_d;
        logic        src_v;
        logic [32:0] trial;
        if (g == 0) begin : g_first
            assign src   = i_data;
            assign src_v = i_vld;
        end else begin : g_next
            assign src   = r_d[g-1];
            assign src_v = r_v[g-1];
        end
        always_comb begin
            n_d = src;
            if (g == 0) begin
                n_d.root = '0;
            end
            trial = (33'(n_d.root) << (K + 1)) + (33'd1 << (2 * K));
            if ({1'b0, n_d.sq} >= trial) begin
                n_d.sq      = n_d.sq - trial[31:0];
                n_d.root[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= src_v;
            end
            if (i_en) begin
                r_d[g] <= n_d;
            end
        end
    end

    // The remainder is x - r*r; round up when it exceeds r.
    t_stage n_round;
    always_comb begin
        n_round     = r_d[RootBits-1];
        n_round.mag = r_d[RootBits-1].root
                    + 16'(r_d[RootBits-1].sq > 32'(r_d[RootBits-1].root));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[RootBits] <= 1'b0;
        end else if (i_en) begin
            r_v[RootBits] <= r_v[RootBits-1];
        end
        if (i_en) begin
            r_d[RootBits] <= n_round;
        end
    end

    assign o_vld  = r_v[RootBits];
    assign o_data = r_d[RootBits];
endmodule
`default_nettype wire

### sv/cpsj_div.sv
// Two-lane pipelined divider for the phasor parts, then result selection and saturation.
`default_nettype none
module cpsj_div
    import cpsj_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire logic   i_vld,
    input  wire t_stage i_data,
    output logic        o_vld,
    output t_stage      o_data
);
    localparam int unsigned Depth = QuotBits + 2;

    logic   r_v [0:Depth-1];
    t_stage r_d [0:Depth-1];
    t_stage n_setup, n_final;

    // Numerator is |part| * 65536 + mag against a divisor of 2 * mag. A quotient of
    // 32768 or more always saturates, so only that flag and 15 bits are needed.
    always_comb begin
        n_setup      = i_data;
        n_setup.nre  = {i_data.ure, 16'h0} + 32'(i_data.mag);
        n_setup.nim  = {i_data.uim, 16'h0} + 32'(i_data.mag);
        n_setup.ovre = n_setup.nre >= {i_data.mag, 16'h0};
        n_setup.ovim = n_setup.nim >= {i_data.mag, 16'h0};
        n_setup.qre  = '0;
        n_setup.qim  = '0;
    end

    for (genvar g = 0; g < QuotBits; g++) begin : g_step
        localparam int unsigned K = QuotBits - 1 - g;
        t_stage      n_d;
        logic [31:0] trial;
        always_comb begin
            n_d   = r_d[g];
            trial = 32'(r_d[g].mag) << (K + 1);
            if (n_d.nre >= trial) begin
                n_d.nre    = n_d.nre - trial;
                n_d.qre[K] = 1'b1;
            end
            if (n_d.nim >= trial) begin
                n_d.nim    = n_d.nim - trial;
                n_d.qim[K] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
            if (i_en) begin
                r_d[g+1] <= n_d;
            end
        end
    end

    function automatic logic [15:0] phasor(input logic neg, input logic ov,
                                           input logic [14:0] q);
        logic [15:0] res;
        if (ov) begin
            res = neg ? SatNeg : SatPos;
        end else begin
            res = neg ? 16'(-{1'b0, q}) : {1'b0, q};
        end
        return res;
    endfunction

    always_comb begin
        n_final = r_d[Depth-2];
        if (r_d[Depth-2].mode == MODE_JOIN) begin
            n_final.re  = r_d[Depth-2].jre;
            n_final.im  = r_d[Depth-2].jim;
            n_final.mag = '0;
        end else if (r_d[Depth-2].mag != 16'h0) begin
            n_final.re = phasor(r_d[Depth-2].re[15], r_d[Depth-2].ovre, r_d[Depth-2].qre);
            n_final.im = phasor(r_d[Depth-2].im[15], r_d[Depth-2].ovim, r_d[Depth-2].qim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0]       <= 1'b0;
            r_v[Depth-1] <= 1'b0;
        end else if (i_en) begin
            r_v[0]       <= i_vld;
            r_v[Depth-1] <= r_v[Depth-2];
        end
        if (i_en) begin
            r_d[0]       <= n_setup;
            r_d[Depth-1] <= n_final;
        end
    end

    assign o_vld  = r_v[Depth-1];
    assign o_data = r_d[Depth-1];
endmodule
`default_nettype wire

### sv/complex_polar_split_join.sv
// Top level of the complex polar split/join block with mode register and output skid.
// One sample is accepted per clock while the skid slot is empty. Each result passes
// the squaring and join-product stages, the bit-per-stage square root and rounding,
// the two-lane bit-per-stage divider and selection, and one output register. A skid
// slot behind the output register keeps the input open for one more transaction while
// a result waits; the pipeline stalls as a whole once the slot is full.
`default_nettype none
`include "complex_polar_split_join_assert.svh"
module complex_polar_split_join
    import cpsj_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cpsj_in_if.sink    i_in,
    cpsj_out_if.source o_out,
    cpsj_cfg_if.sink   i_cfg
);
    t_mode  r_mode;
    logic   en;
    t_stage in_data;
    logic   front_v, sqrt_v, pipe_v;
    t_stage front_d, sqrt_d, pipe_d;
    logic   r_out_v, r_skid_v;
    t_stage r_out, r_skid;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SPLIT;
        end else if (i_cfg.valid) begin
            r_mode <= t_mode'(i_cfg.data);
        end
    end

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    always_comb begin
        in_data      = '0;
        in_data.mode = r_mode;
        in_data.re   = i_in.in_re;
        in_data.im   = i_in.in_im;
        in_data.mag  = i_in.in_mag;
    end

    cpsj_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(i_in.valid), .i_data(in_data), .o_vld(front_v), .o_data(front_d)
    );

    cpsj_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(front_v), .i_data(front_d), .o_vld(sqrt_v), .o_data(sqrt_d)
    );

    cpsj_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(sqrt_v), .i_data(sqrt_d), .o_vld(pipe_v), .o_data(pipe_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= pipe_v;
            end
        end else if (pipe_v && en) begin
            r_skid_v <= 1'b1;
        end
        if (!r_out_v || o_out.ready) begin
            r_out <= r_skid_v ? r_skid : pipe_d;
        end else if (en) begin
            r_skid <= pipe_d;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.out_re  = r_out.re;
    assign o_out.out_im  = r_out.im;
    assign o_out.out_mag = r_out.mag;

    `CPSJ_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `CPSJ_ASSERT_NXT(a_skid_fills, i_clk, i_rst_n,
        !r_skid_v && r_out_v && !o_out.ready && pipe_v, r_skid_v && r_out_v)
    `CPSJ_ASSERT_IMP(a_join_mag_zero, i_clk, i_rst_n,
        r_out_v && r_out.mode == MODE_JOIN, r_out.mag == 16'h0)
endmodule
`default_nettype wire

### tb/cpsj_checker.sv
// Checker that watches the complex polar split/join channels and compares results.
module cpsj_checker
    import cpsj_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] in_re,
    input  logic [15:0] in_im,
    input  logic [15:0] in_mag,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_re,
    input  logic [15:0] out_im,
    input  logic [15:0] out_mag,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [15:0] mag;
    } t_polar;

    t_mode    mode_q;
    t_polar   expected_polar[$];

    function automatic longint unsigned round_sqrt(longint unsigned x);
        longint unsigned r;
        r = 0;
        while ((r + 1) * (r + 1) <= x) r++;
        // Round up when x is past the midpoint r*r + r.
        if (x - r * r > r) r++;
        return r;
    endfunction

    function automatic logic [15:0] saturate(longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    function automatic logic [15:0] phasor_part(longint a, longint unsigned d);
        longint unsigned ua, q;
        ua = (a < 0) ? -a : a;
        q = (ua * 65536 + d) / (2 * d);
        return saturate((a < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic logic [15:0] scale_part(longint a, longint unsigned m);
        longint unsigned ua, q;
        ua = (a < 0) ? -a : a;
        q = (ua * m + 16384) >> 15;
        return saturate((a < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_polar polar_result(t_mode m, logic [15:0] re_b, logic [15:0] im_b,
                                            logic [15:0] mag_b);
        t_polar r;
        longint re, im;
        longint unsigned mag;
        re = longint'($signed(re_b));
        im = longint'($signed(im_b));
        if (m == MODE_SPLIT) begin
            mag = round_sqrt(re * re + im * im);
            if (mag == 0) begin
                r.re = re_b;
                r.im = im_b;
            end else begin
                r.re = phasor_part(re, mag);
                r.im = phasor_part(im, mag);
            end
            r.mag = mag[15:0];
        end else begin
            r.re = scale_part(re, mag_b);
            r.im = scale_part(im, mag_b);
            r.mag = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_polar e;
        if (!i_rst_n) begin
            mode_q <= MODE_SPLIT;
        end else begin
            if (cfg_valid && cfg_ready) mode_q <= t_mode'(cfg_data);
            if (in_valid && in_ready)
                expected_polar.push_back(polar_result(mode_q, in_re, in_im, in_mag));
            if (out_valid && out_ready) begin
                if (expected_polar.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    e = expected_polar.pop_front();
                    if (out_re !== e.re) begin
                        $error("out_re expected %h actual %h", e.re, out_re);
                        o_fail_count++;
                    end
                    if (out_im !== e.im) begin
                        $error("out_im expected %h actual %h", e.im, out_im);
                        o_fail_count++;
                    end
                    if (out_mag !== e.mag) begin
                        $error("out_mag expected %h actual %h", e.mag, out_mag);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_polar.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

### tb/testbench.sv
// Top of the complex polar split/join testbench: stimulus, clock, reset and verdict.
module testbench;
    import cpsj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Latency = 64;
    localparam longint CycleLimit = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    longint cycles = 0;

    cpsj_in_if  in_ch();
    cpsj_out_if out_ch();
    cpsj_cfg_if cfg_ch();

    complex_polar_split_join dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    cpsj_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_re(in_ch.in_re),
        .in_im(in_ch.in_im), .in_mag(in_ch.in_mag),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_re(out_ch.out_re),
        .out_im(out_ch.out_im), .out_mag(out_ch.out_mag),
        .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // After an accepted result the receiver may drop ready for a random stall.
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.ready && out_ch.valid) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_mode(t_mode m);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Valid is dropped only when a gap follows, so back-to-back transactions stay asserted.
    task automatic send_sample(logic [15:0] re, logic [15:0] im, logic [15:0] mag,
                               bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_re <= re;
        in_ch.in_im <= im;
        in_ch.in_mag <= mag;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
    endtask

    // Random samples, some small for the split side to exercise saturation.
    task automatic random_phase(int count);
        logic [15:0] re, im, mag;
        bit burst;
        for (int k = 0; k < count; k++) begin
            re = 16'($urandom);
            im = 16'($urandom);
            mag = 16'($urandom);
            case ($urandom_range(0, 5))
                0: begin
                    re = 16'($signed(6'($urandom)) >>> 2);
                    im = 16'($signed(6'($urandom)) >>> 2);
                end
                1: mag = 16'($urandom_range(0, 46341));
                2: re = 16'h8000;
                default: ;
            endcase
            burst = (k % 100) < 20;
            send_sample(re, im, mag, burst);
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.in_re = '0;
        in_ch.in_im = '0;
        in_ch.in_mag = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Split mode after reset: zero, extremes, tiny samples, negative full scale.
        send_sample(16'h0000, 16'h0000, 16'h0000, 0);
        send_sample(16'h8000, 16'h8000, 16'hFFFF, 0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h0000, 0);
        send_sample(16'h8000, 16'h0000, 16'h0000, 0);
        send_sample(16'h0001, 16'h0000, 16'h0000, 0);
        send_sample(16'hFFFF, 16'h0001, 16'h0000, 0);
        send_sample(16'h8000, 16'h0001, 16'h0000, 0);
        send_sample(16'h0000, 16'h7FFF, 16'h0000, 0);
        random_phase(200);
        drain();

        write_mode(MODE_JOIN);
        send_sample(16'h7FFF, 16'h8000, 16'hFFFF, 0);
        send_sample(16'h7FFF, 16'h8000, 16'h0000, 0);
        send_sample(16'h8000, 16'h7FFF, 16'hB505, 0);
        send_sample(16'h4000, 16'hC000, 16'h8000, 0);
        send_sample(16'h0001, 16'hFFFF, 16'h4000, 0);
        send_sample(16'h0000, 16'h0000, 16'hFFFF, 0);
        random_phase(250);
        drain();

        write_mode(MODE_SPLIT);
        random_phase(120);
        drain();
        write_mode(MODE_JOIN);
        random_phase(120);
        drain();

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule

### complex_polar_split_join.f
+incdir+sv
sv/cpsj_pkg.sv
sv/cpsj_if.sv
sv/cpsj_front.sv
sv/cpsj_sqrt.sv
sv/cpsj_div.sv
sv/complex_polar_split_join.sv
tb/cpsj_checker.sv
tb/testbench.sv
